[rtl/mcid_pkg.sv]
// ----------------------------------------------------------------------------
// mcid_pkg: shared types and constants for the motion channel identifier
// Register index codes, register widths and reset values, and the control
// word that the top level hands to the mark store.
// ----------------------------------------------------------------------------
package mcid_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOM_MARGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 3'd3;

	// register widths
	localparam int RANGE_CFG_W  = 10;
	localparam int STABLE_W     = 4;
	localparam int SETTLE_W     = 10;

	// register reset values
	localparam logic [RANGE_CFG_W-1:0] MIN_RANGE_RST  = 10'd80;
	localparam logic [RANGE_CFG_W-1:0] DOM_MARGIN_RST = 10'd20;
	localparam logic [STABLE_W-1:0]    STABLE_RST     = 4'd5;
	localparam logic [SETTLE_W-1:0]    SETTLE_RST     = 10'd150;

	// per-sample commands to the mark store
	typedef struct packed {
		logic load;   // settling: marks take the sample
		logic track;  // tracking: widen marks of an unused channel
		logic take;   // scan end capture: flag take_idx as used
	} mark_ctl_t;

endpackage

[rtl/motion_channel_identifier.sv]
// ----------------------------------------------------------------------------
// motion_channel_identifier: assigns one moving converter channel per target
// Path: a scan-end sample goes through the input register and then the result
// register, which loads as the sample leaves the input register.
// Throughput: one sample per cycle; samples keep flowing while a result word
// waits, only a scan-end sample holds in the input register until the result
// register is free.
// Reset: control state, used-channel flags and registers return to defaults
// at once; the low/high marks are not cleared (each settling scan loads them).
// ----------------------------------------------------------------------------
module motion_channel_identifier #(
	parameter int ADC_DEVICES      = 3,
	parameter int CHANNELS_PER_ADC = 8,
	parameter int TARGET_COUNT     = 24,
	parameter int SAMPLE_BITS      = 10,
	localparam int DEV_W  = (ADC_DEVICES > 1) ? $clog2(ADC_DEVICES) : 1,
	localparam int CH_W   = (CHANNELS_PER_ADC > 1) ? $clog2(CHANNELS_PER_ADC) : 1,
	localparam int TGT_W  = $clog2(TARGET_COUNT + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [DEV_W-1:0]                adc_device,
	input  logic [CH_W-1:0]                 adc_channel,
	input  logic [SAMPLE_BITS-1:0]          sample,
	input  logic                            last_in_scan,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            candidate_found,
	output logic [DEV_W-1:0]                candidate_device,
	output logic [CH_W-1:0]                 candidate_channel,
	output logic [SAMPLE_BITS-1:0]          candidate_range,
	output logic                            ambiguous,
	output logic                            captured,
	output logic [TGT_W-1:0]                mapped_target,
	output logic [TGT_W-1:0]                completed_count,
	output logic                            waiting_motion,
	output logic                            all_done,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mcid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mcid_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int SLOTS  = ADC_DEVICES * CHANNELS_PER_ADC;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	// compare width for range against the 10-bit thresholds plus margin
	localparam int CMP_W  = ((SAMPLE_BITS > mcid_pkg::RANGE_CFG_W) ?
	                         SAMPLE_BITS : mcid_pkg::RANGE_CFG_W) + 1;

	// phase codes
	localparam logic [1:0] PH_SETTLE = 2'd0;
	localparam logic [1:0] PH_TRACK  = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	// ---------------- configuration registers ----------------
	logic [mcid_pkg::RANGE_CFG_W-1:0] min_range_q;
	logic [mcid_pkg::RANGE_CFG_W-1:0] dom_margin_q;
	logic [mcid_pkg::STABLE_W-1:0]    stable_q;
	logic [mcid_pkg::SETTLE_W-1:0]    settle_scans_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q    <= mcid_pkg::MIN_RANGE_RST;
			dom_margin_q   <= mcid_pkg::DOM_MARGIN_RST;
			stable_q       <= mcid_pkg::STABLE_RST;
			settle_scans_q <= mcid_pkg::SETTLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mcid_pkg::CFG_MIN_RANGE:  min_range_q    <= cfg_data;
				mcid_pkg::CFG_DOM_MARGIN: dom_margin_q   <= cfg_data;
				mcid_pkg::CFG_STABLE:     stable_q       <= cfg_data[mcid_pkg::STABLE_W-1:0];
				mcid_pkg::CFG_SETTLE:     settle_scans_q <= cfg_data;
				default: ;  // unknown index: word dropped
			endcase
		end
	end

	// ---------------- input register ----------------
	logic                   valid_s1;
	logic [DEV_W-1:0]       dev_s1;
	logic [CH_W-1:0]        ch_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;
	logic                   last_s1;

	logic out_valid_q;
	logic proc;  // the held sample is consumed this cycle

	// a scan-end sample needs the result register; everything else goes through
	assign proc     = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			dev_s1  <= adc_device;
			ch_s1   <= adc_channel;
			smp_s1  <= sample;
			last_s1 <= last_in_scan;
		end
	end

	// ---------------- slot decode and mark store ----------------
	logic              slot_ok;
	logic [SLOT_W-1:0] slot;
	logic [SLOT_W-1:0] idx;

	assign slot_ok = ({1'b0, dev_s1} < (DEV_W + 1)'(ADC_DEVICES)) &&
	                 ({1'b0, ch_s1} < (CH_W + 1)'(CHANNELS_PER_ADC));
	assign slot    = SLOT_W'(dev_s1) * SLOT_W'(CHANNELS_PER_ADC) + SLOT_W'(ch_s1);
	assign idx     = slot_ok ? slot : '0;

	// scan state
	logic [1:0]                    phase_q;
	logic [mcid_pkg::SETTLE_W-1:0] settle_cnt_q;
	logic [SAMPLE_BITS-1:0]        best_q;
	logic [SAMPLE_BITS-1:0]        second_q;
	logic [SLOT_W-1:0]             best_slot_q;
	logic [DEV_W-1:0]              best_dev_q;
	logic [CH_W-1:0]               best_ch_q;
	logic                          best_valid_q;
	logic [SLOT_W-1:0]             streak_slot_q;
	logic                          streak_valid_q;
	logic [mcid_pkg::STABLE_W-1:0] streak_cnt_q;
	logic [TGT_W-1:0]              target_q;

	// running best including the sample in hand
	logic [SAMPLE_BITS-1:0] b_rng;
	logic [SAMPLE_BITS-1:0] b_sec;
	logic [SLOT_W-1:0]      b_slot;
	logic [DEV_W-1:0]       b_dev;
	logic [CH_W-1:0]        b_ch;
	logic                   b_valid;

	mcid_pkg::mark_ctl_t    mctl;
	logic                   avail;
	logic [SAMPLE_BITS-1:0] rng;
	logic                   hit;
	logic                   scan_end;
	logic                   cap;

	assign hit        = proc && slot_ok;
	assign scan_end   = proc && last_s1;
	assign mctl.load  = hit && (phase_q == PH_SETTLE);
	assign mctl.track = hit && (phase_q == PH_TRACK);
	assign mctl.take  = cap;

	// the scan-end sample itself may set the best slot
	mcid_marks #(
		.SLOTS       (SLOTS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_marks (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mctl),
		.idx      (idx),
		.smp      (smp_s1),
		.take_idx (b_slot),
		.avail    (avail),
		.rng      (rng)
	);

	// ---------------- running best / second range ----------------
	always_comb begin
		b_rng   = best_q;
		b_sec   = second_q;
		b_slot  = best_slot_q;
		b_dev   = best_dev_q;
		b_ch    = best_ch_q;
		b_valid = best_valid_q;
		if (mctl.track && avail) begin
			if (rng > best_q) begin
				b_sec   = best_q;
				b_rng   = rng;
				b_slot  = idx;
				b_dev   = dev_s1;
				b_ch    = ch_s1;
				b_valid = 1'b1;
			end else if (rng > second_q) begin
				b_sec = rng;
			end
		end
	end

	// ---------------- scan-end decision ----------------
	logic                          ge_min;
	logic                          dominant;
	logic                          same_streak;
	logic [mcid_pkg::SETTLE_W:0]   settle_inc;
	logic [TGT_W-1:0]              tgt_inc;

	logic [1:0]                    phase_d;
	logic [mcid_pkg::SETTLE_W-1:0] settle_cnt_d;
	logic [SLOT_W-1:0]             streak_slot_d;
	logic                          streak_valid_d;
	logic [mcid_pkg::STABLE_W-1:0] streak_cnt_d;
	logic [TGT_W-1:0]              target_d;
	logic                          found_d;
	logic                          amb_d;

	assign ge_min      = CMP_W'(b_rng) >= CMP_W'(min_range_q);
	assign dominant    = b_valid && ge_min &&
	                     (CMP_W'(b_rng) >= CMP_W'(b_sec) + CMP_W'(dom_margin_q));
	assign same_streak = streak_valid_q && (streak_slot_q == b_slot);
	assign settle_inc  = {1'b0, settle_cnt_q} + 1'b1;
	assign tgt_inc     = target_q + 1'b1;

	always_comb begin
		phase_d        = phase_q;
		settle_cnt_d   = settle_cnt_q;
		streak_slot_d  = streak_slot_q;
		streak_valid_d = streak_valid_q;
		streak_cnt_d   = streak_cnt_q;
		target_d       = target_q;
		found_d        = 1'b0;
		amb_d          = 1'b0;
		cap            = 1'b0;
		if (scan_end) begin
			unique case (phase_q)
				PH_SETTLE: begin
					if (settle_inc >= {1'b0, settle_scans_q}) begin
						phase_d        = PH_TRACK;
						settle_cnt_d   = '0;
						streak_valid_d = 1'b0;
						streak_cnt_d   = '0;
					end else begin
						settle_cnt_d = settle_inc[mcid_pkg::SETTLE_W-1:0];
					end
				end
				PH_TRACK: begin
					found_d = b_valid;
					amb_d   = b_valid && ge_min && !dominant;
					priority if (!dominant) begin
						streak_cnt_d = '0;
					end else if (!same_streak) begin
						streak_slot_d  = b_slot;
						streak_valid_d = 1'b1;
						streak_cnt_d   = mcid_pkg::STABLE_W'(1);
					end else if (streak_cnt_q < stable_q) begin
						streak_cnt_d = streak_cnt_q + 1'b1;
					end else begin
						// held long enough: claim the channel for this target
						cap          = 1'b1;
						target_d     = tgt_inc;
						settle_cnt_d = '0;
						phase_d      = (tgt_inc >= TGT_W'(TARGET_COUNT)) ? PH_DONE : PH_SETTLE;
					end
				end
				PH_DONE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SETTLE;
			settle_cnt_q   <= '0;
			best_q         <= '0;
			second_q       <= '0;
			best_slot_q    <= '0;
			best_dev_q     <= '0;
			best_ch_q      <= '0;
			best_valid_q   <= 1'b0;
			streak_slot_q  <= '0;
			streak_valid_q <= 1'b0;
			streak_cnt_q   <= '0;
			target_q       <= '0;
		end else if (proc) begin
			phase_q        <= phase_d;
			settle_cnt_q   <= settle_cnt_d;
			streak_slot_q  <= streak_slot_d;
			streak_valid_q <= streak_valid_d;
			streak_cnt_q   <= streak_cnt_d;
			target_q       <= target_d;
			// running best clears at every scan end
			if (last_s1) begin
				best_q       <= '0;
				second_q     <= '0;
				best_slot_q  <= '0;
				best_dev_q   <= '0;
				best_ch_q    <= '0;
				best_valid_q <= 1'b0;
			end else begin
				best_q       <= b_rng;
				second_q     <= b_sec;
				best_slot_q  <= b_slot;
				best_dev_q   <= b_dev;
				best_ch_q    <= b_ch;
				best_valid_q <= b_valid;
			end
		end
	end

	// ---------------- result register ----------------
	logic                   found_q;
	logic [DEV_W-1:0]       cdev_q;
	logic [CH_W-1:0]        cch_q;
	logic [SAMPLE_BITS-1:0] crange_q;
	logic                   amb_q;
	logic                   cap_q;
	logic [TGT_W-1:0]       mapped_q;
	logic [TGT_W-1:0]       count_q;
	logic                   waiting_q;
	logic                   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (scan_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_end) begin
			found_q   <= found_d;
			cdev_q    <= found_d ? b_dev : '0;
			cch_q     <= found_d ? b_ch : '0;
			crange_q  <= found_d ? b_rng : '0;
			amb_q     <= amb_d;
			cap_q     <= cap;
			mapped_q  <= cap ? target_q : target_d;
			count_q   <= target_d;
			waiting_q <= (phase_d == PH_TRACK);
			done_q    <= (phase_d == PH_DONE);
		end
	end

	assign out_valid         = out_valid_q;
	assign candidate_found   = found_q;
	assign candidate_device  = cdev_q;
	assign candidate_channel = cch_q;
	assign candidate_range   = crange_q;
	assign ambiguous         = amb_q;
	assign captured          = cap_q;
	assign mapped_target     = mapped_q;
	assign completed_count   = count_q;
	assign waiting_motion    = waiting_q;
	assign all_done          = done_q;

endmodule

[rtl/mcid_marks.sv]
// ----------------------------------------------------------------------------
// mcid_marks: per-channel low/high marks and channel-used flags
// One read-modify-write per cycle at the addressed slot; reports the range
// after folding in the sample and whether the slot is still unused.
// ----------------------------------------------------------------------------
module mcid_marks #(
	parameter int SLOTS       = 24,
	parameter int SAMPLE_BITS = 10,
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mcid_pkg::mark_ctl_t     ctl,
	input  logic [SLOT_W-1:0]       idx,
	input  logic [SAMPLE_BITS-1:0]  smp,
	input  logic [SLOT_W-1:0]       take_idx,
	output logic                    avail,
	output logic [SAMPLE_BITS-1:0]  rng
);

	logic [SAMPLE_BITS-1:0] low_q  [SLOTS];
	logic [SAMPLE_BITS-1:0] high_q [SLOTS];
	logic [SLOTS-1:0]       taken_q;

	logic [SAMPLE_BITS-1:0] lo;
	logic [SAMPLE_BITS-1:0] hi;
	logic [SAMPLE_BITS-1:0] new_lo;
	logic [SAMPLE_BITS-1:0] new_hi;

	always_comb begin
		lo     = low_q[idx];
		hi     = high_q[idx];
		new_lo = (smp < lo) ? smp : lo;
		new_hi = (smp > hi) ? smp : hi;
		rng    = (new_hi >= new_lo) ? (new_hi - new_lo) : '0;
		avail  = !taken_q[idx];
	end

	// marks are undefined until the first settling scan writes them
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			low_q[idx]  <= smp;
			high_q[idx] <= smp;
		end else if (ctl.track && avail) begin
			low_q[idx]  <= new_lo;
			high_q[idx] <= new_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
		end else if (ctl.take) begin
			taken_q[take_idx] <= 1'b1;
		end
	end

endmodule

[rtl/mcid_checker.sv]
// ----------------------------------------------------------------------------
// mcid_checker: port-level checks for the motion channel identifier
// Watches the result channel and the target bookkeeping it reports.
// ----------------------------------------------------------------------------
module mcid_checker #(
	parameter int TGT_W = 5
) (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic             captured,
	input logic             waiting_motion,
	input logic             all_done,
	input logic [TGT_W-1:0] mapped_target,
	input logic [TGT_W-1:0] completed_count
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(completed_count))
		else $error("result word changed while stalled");

	// a capture advances the count past the target just assigned
	a_cap_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && captured |-> completed_count == mapped_target + TGT_W'(1))
		else $error("capture count mismatch");

	// after a capture the block is settling or finished, never tracking
	a_cap_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && captured |-> !waiting_motion)
		else $error("tracking right after capture");

	// without a capture the reported target is the current count
	a_map_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !captured |-> mapped_target == completed_count)
		else $error("mapped target differs from count");

	// done and tracking exclude each other
	a_done_track: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(all_done && waiting_motion))
		else $error("done while tracking");

endmodule

bind motion_channel_identifier mcid_checker #(
	.TGT_W (TGT_W)
) u_mcid_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.captured        (captured),
	.waiting_motion  (waiting_motion),
	.all_done        (all_done),
	.mapped_target   (mapped_target),
	.completed_count (completed_count)
);
